>>> sv/pcrc_pkg.sv
// Shared types and constants for the pixel color ratio classifier.
`default_nettype none

package pcrc_pkg;

    localparam int unsigned CH_W     = 8;
    localparam int unsigned TOTAL_W  = 24;
    localparam int unsigned TALLY_W  = 17;
    localparam int unsigned THR_W    = 16;
    localparam int unsigned CLASS_W  = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned PROD_W   = TOTAL_W + THR_W;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam logic [THR_W-1:0]   Q_ONE     = 16'd256;

    // reset values of the configuration registers
    localparam logic [THR_W-1:0] RST_RATIO_THR        = 16'd512;
    localparam logic [CH_W-1:0]  RST_MIN_PIXELS       = 8'd8;
    localparam logic [CH_W-1:0]  RST_SATURATION_LEVEL = 8'd245;
    localparam logic [CH_W-1:0]  RST_DARK_LEVEL       = 8'd40;

    localparam logic [CFG_IDX_W-1:0] REG_RATIO_THR        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PIXELS       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SATURATION_LEVEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DARK_LEVEL       = 3'd3;

    typedef enum logic [CLASS_W-1:0] {
        CLASS_UNKNOWN = 2'd0,
        CLASS_RED     = 2'd1,
        CLASS_BLUE    = 2'd2
    } t_color_class;

    typedef struct packed {
        logic [THR_W-1:0] ratio_thr;
        logic [CH_W-1:0]  min_pixels;
        logic [CH_W-1:0]  saturation_level;
        logic [CH_W-1:0]  dark_level;
    } t_cfg;

    typedef struct packed {
        logic             region_end;
        logic [CH_W-1:0]  red_level;
        logic [CH_W-1:0]  green_level;
        logic [CH_W-1:0]  blue_level;
    } t_pixel;

    // region totals handed from the accumulator to the decision stage
    typedef struct packed {
        logic [TOTAL_W-1:0] red_total;
        logic [TOTAL_W-1:0] blue_total;
        logic [TALLY_W-1:0] pixel_tally;
    } t_snap;

endpackage

`default_nettype wire

>>> sv/pcrc_accum.sv
// Pixel input register, skip filter and saturating region accumulators.
`default_nettype none

module pcrc_accum #(
    parameter int unsigned MAX_REGION_PIXELS = 65536
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire pcrc_pkg::t_cfg  i_cfg,
    input  wire logic            i_pix_valid,
    output logic                 o_pix_ready,
    input  wire pcrc_pkg::t_pixel i_pix,
    output logic                 o_snap_valid,
    input  wire logic            i_snap_ready,
    output pcrc_pkg::t_snap      o_snap
);

    localparam int unsigned TALLY_LIMIT = (1 << pcrc_pkg::TALLY_W) - 1;
    localparam int unsigned TALLY_CAP_I =
        (MAX_REGION_PIXELS < TALLY_LIMIT) ? MAX_REGION_PIXELS : TALLY_LIMIT;
    localparam logic [pcrc_pkg::TALLY_W-1:0] TALLY_CAP = TALLY_CAP_I[pcrc_pkg::TALLY_W-1:0];

    logic              r_pix_valid;
    pcrc_pkg::t_pixel  r_pix;
    logic              r_snap_valid;
    pcrc_pkg::t_snap   r_snap;
    logic [pcrc_pkg::TOTAL_W-1:0] r_red_total;
    logic [pcrc_pkg::TOTAL_W-1:0] r_blue_total;
    logic [pcrc_pkg::TALLY_W-1:0] r_tally;

    logic [pcrc_pkg::TOTAL_W-1:0] n_red_total;
    logic [pcrc_pkg::TOTAL_W-1:0] n_blue_total;
    logic [pcrc_pkg::TALLY_W-1:0] n_tally;
    logic [pcrc_pkg::TOTAL_W:0]   red_sum;
    logic [pcrc_pkg::TOTAL_W:0]   blue_sum;
    logic snap_free;
    logic consume;
    logic bright;
    logic dark;
    logic counted;

    assign snap_free   = !r_snap_valid || i_snap_ready;
    // the last beat of a region waits until the snapshot register is free
    assign consume     = r_pix_valid && (!r_pix.region_end || snap_free);
    assign o_pix_ready = !r_pix_valid || consume;

    assign bright = (r_pix.blue_level  >= i_cfg.saturation_level)
                 && (r_pix.green_level >= i_cfg.saturation_level)
                 && (r_pix.red_level   >= i_cfg.saturation_level);
    assign dark   = (r_pix.blue_level  < i_cfg.dark_level)
                 && (r_pix.green_level < i_cfg.dark_level)
                 && (r_pix.red_level   < i_cfg.dark_level);
    assign counted = !bright && !dark;

    always_comb begin
        red_sum  = {1'b0, r_red_total}
                 + {{(pcrc_pkg::TOTAL_W + 1 - pcrc_pkg::CH_W){1'b0}}, r_pix.red_level};
        blue_sum = {1'b0, r_blue_total}
                 + {{(pcrc_pkg::TOTAL_W + 1 - pcrc_pkg::CH_W){1'b0}}, r_pix.blue_level};
        n_red_total  = r_red_total;
        n_blue_total = r_blue_total;
        n_tally      = r_tally;
        if (counted) begin
            n_red_total  = red_sum[pcrc_pkg::TOTAL_W] ? pcrc_pkg::TOTAL_MAX
                                                      : red_sum[pcrc_pkg::TOTAL_W-1:0];
            n_blue_total = blue_sum[pcrc_pkg::TOTAL_W] ? pcrc_pkg::TOTAL_MAX
                                                       : blue_sum[pcrc_pkg::TOTAL_W-1:0];
            if (r_tally < TALLY_CAP) begin
                n_tally = r_tally + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_valid  <= 1'b0;
            r_snap_valid <= 1'b0;
            r_red_total  <= '0;
            r_blue_total <= '0;
            r_tally      <= '0;
        end else begin
            if (o_pix_ready) begin
                r_pix_valid <= i_pix_valid;
            end
            if (consume) begin
                if (r_pix.region_end) begin
                    r_red_total  <= '0;
                    r_blue_total <= '0;
                    r_tally      <= '0;
                end else begin
                    r_red_total  <= n_red_total;
                    r_blue_total <= n_blue_total;
                    r_tally      <= n_tally;
                end
            end
            if (consume && r_pix.region_end) begin
                r_snap_valid <= 1'b1;
            end else if (i_snap_ready) begin
                r_snap_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pix_ready && i_pix_valid) begin
            r_pix <= i_pix;
        end
        if (consume && r_pix.region_end) begin
            r_snap.red_total   <= n_red_total;
            r_snap.blue_total  <= n_blue_total;
            r_snap.pixel_tally <= n_tally;
        end
    end

    assign o_snap_valid = r_snap_valid;
    assign o_snap       = r_snap;

endmodule

`default_nettype wire

>>> sv/pcrc_decide.sv
// Ratio decision by cross multiplication and the result register.
`default_nettype none

module pcrc_decide (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire pcrc_pkg::t_cfg                i_cfg,
    input  wire logic                          i_snap_valid,
    output logic                               o_snap_ready,
    input  wire pcrc_pkg::t_snap               i_snap,
    output logic                               o_res_valid,
    input  wire logic                          i_res_ready,
    output pcrc_pkg::t_color_class             o_color_class,
    output logic [pcrc_pkg::TALLY_W-1:0]       o_pixels_used
);

    logic                                 r_res_valid;
    pcrc_pkg::t_color_class               r_color_class;
    logic [pcrc_pkg::TALLY_W-1:0]         r_pixels_used;

    pcrc_pkg::t_color_class               n_color_class;
    logic [pcrc_pkg::THR_W-1:0]           thr;
    logic [pcrc_pkg::TOTAL_W-1:0]         blue_eff;
    logic [pcrc_pkg::PROD_W-1:0]          red_q;
    logic [pcrc_pkg::PROD_W-1:0]          blue_q;
    logic [pcrc_pkg::PROD_W-1:0]          thr_blue;
    logic [pcrc_pkg::PROD_W-1:0]          red_thr;
    logic                                 too_few;

    assign o_snap_ready = !r_res_valid || i_res_ready;

    always_comb begin
        thr      = (i_cfg.ratio_thr < pcrc_pkg::Q_ONE) ? pcrc_pkg::Q_ONE
                                                       : i_cfg.ratio_thr;
        blue_eff = (i_snap.blue_total == '0) ? pcrc_pkg::TOTAL_W'(1) : i_snap.blue_total;
        // times 256 is a shift
        red_q    = {{(pcrc_pkg::PROD_W - pcrc_pkg::TOTAL_W - 8){1'b0}}, i_snap.red_total, 8'h00};
        blue_q   = {{(pcrc_pkg::PROD_W - pcrc_pkg::TOTAL_W - 8){1'b0}}, blue_eff, 8'h00};
        thr_blue = pcrc_pkg::PROD_W'(thr) * pcrc_pkg::PROD_W'(blue_eff);
        red_thr  = pcrc_pkg::PROD_W'(thr) * pcrc_pkg::PROD_W'(i_snap.red_total);
        too_few  = i_snap.pixel_tally
                 < {{(pcrc_pkg::TALLY_W - pcrc_pkg::CH_W){1'b0}}, i_cfg.min_pixels};
        if (too_few) begin
            n_color_class = pcrc_pkg::CLASS_UNKNOWN;
        end else if (red_q > thr_blue) begin
            n_color_class = pcrc_pkg::CLASS_RED;
        end else if (red_thr < blue_q) begin
            n_color_class = pcrc_pkg::CLASS_BLUE;
        end else begin
            n_color_class = pcrc_pkg::CLASS_UNKNOWN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (o_snap_ready) begin
            r_res_valid <= i_snap_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_snap_ready && i_snap_valid) begin
            r_color_class <= n_color_class;
            r_pixels_used <= i_snap.pixel_tally;
        end
    end

    assign o_res_valid   = r_res_valid;
    assign o_color_class = r_color_class;
    assign o_pixels_used = r_pixels_used;

endmodule

`default_nettype wire

>>> sv/pixel_color_ratio_classifier.sv
// Top level: configuration registers, stream ports and the two processing stages.
`default_nettype none

// Classifies a region of BGR pixels as red, blue or unknown from its red to blue
// ratio. One pixel beat is taken every clock cycle unless a result is stuck at the
// output; mid-region pixels only update the saturating accumulators, and the beat
// flagged tlast yields one result beat on the output through the input register,
// then the accumulator snapshot, then the cross-multiply compare into the result
// register. The rate is set by the accumulator loop, so regions may follow back
// to back with no gap. Configuration is written
// through i_cfg_we/i_cfg_idx/i_cfg_data and should only change while no region
// is in flight.
module pixel_color_ratio_classifier #(
    parameter int unsigned MAX_REGION_PIXELS = 65536
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [pcrc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [pcrc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [7:0] blue_level, [15:8] green_level, [23:16] red_level
    input  wire logic [23:0]                       s_axis_tdata,
    // region_end
    input  wire logic                              s_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [1:0] color_class, [18:2] pixels_used, [23:19] zero
    output logic [23:0]                            m_axis_tdata
);

    pcrc_pkg::t_cfg          r_cfg;
    pcrc_pkg::t_pixel        pix;
    pcrc_pkg::t_snap         snap;
    pcrc_pkg::t_color_class  color_class;
    logic [pcrc_pkg::TALLY_W-1:0] pixels_used;
    logic snap_valid;
    logic snap_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ratio_thr        <= pcrc_pkg::RST_RATIO_THR;
            r_cfg.min_pixels       <= pcrc_pkg::RST_MIN_PIXELS;
            r_cfg.saturation_level <= pcrc_pkg::RST_SATURATION_LEVEL;
            r_cfg.dark_level       <= pcrc_pkg::RST_DARK_LEVEL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pcrc_pkg::REG_RATIO_THR: begin
                    r_cfg.ratio_thr <= i_cfg_data;
                end
                pcrc_pkg::REG_MIN_PIXELS: begin
                    r_cfg.min_pixels <= i_cfg_data[pcrc_pkg::CH_W-1:0];
                end
                pcrc_pkg::REG_SATURATION_LEVEL: begin
                    r_cfg.saturation_level <= i_cfg_data[pcrc_pkg::CH_W-1:0];
                end
                pcrc_pkg::REG_DARK_LEVEL: begin
                    r_cfg.dark_level <= i_cfg_data[pcrc_pkg::CH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign pix.blue_level  = s_axis_tdata[7:0];
    assign pix.green_level = s_axis_tdata[15:8];
    assign pix.red_level   = s_axis_tdata[23:16];
    assign pix.region_end  = s_axis_tlast;

    pcrc_accum #(
        .MAX_REGION_PIXELS(MAX_REGION_PIXELS)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_pix_valid (s_axis_tvalid),
        .o_pix_ready (s_axis_tready),
        .i_pix       (pix),
        .o_snap_valid(snap_valid),
        .i_snap_ready(snap_ready),
        .o_snap      (snap)
    );

    pcrc_decide u_decide (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_snap_valid (snap_valid),
        .o_snap_ready (snap_ready),
        .i_snap       (snap),
        .o_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .o_color_class(color_class),
        .o_pixels_used(pixels_used)
    );

    assign m_axis_tdata = {5'b0, pixels_used, color_class};

    // input only backs up when a result is stuck downstream
    a_ready_low_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled while output is not backed up");

    a_class_code_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3))
        else $error("illegal color class code");

    // a red call needs red from at least one counted pixel
    a_red_has_pixels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[1:0] == pcrc_pkg::CLASS_RED))
            |-> (m_axis_tdata[18:2] != '0))
        else $error("red class with no counted pixels");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[23:19] == 5'b0))
        else $error("result padding bits not zero");

endmodule

`default_nettype wire
